@@ sv/tmp_pkg.sv @@
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types, codes and fixed-point constants of the trapezoidal move
// profile core and its iterative arithmetic unit.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int POS_W          = 32;
  localparam int EXT_W          = POS_W + 2;
  localparam int TIME_FRAC_BITS = 8;
  localparam int TIME_W         = 40;
  localparam int X_W            = TIME_W + 2;
  localparam int REG_W          = 32;
  localparam int ACC_W          = 2 * X_W + REG_W;
  localparam int B_W            = X_W;

  localparam int T_SHIFT   = 8 + TIME_FRAC_BITS;
  localparam int SD_SHIFT  = 16 + TIME_FRAC_BITS;
  localparam int C_SHIFT   = 16 + TIME_FRAC_BITS;
  localparam int HAD_SHIFT = 25 + 2 * TIME_FRAC_BITS;
  localparam int SQ_SHIFT  = 24 + 2 * TIME_FRAC_BITS;

  localparam int NUM_W       = REG_W + SQ_SHIFT;
  localparam int DIV_STEPS   = NUM_W;
  localparam int SQRT_STEPS  = NUM_W / 2;
  localparam int REM_W       = NUM_W / 2 + 4;
  localparam int CNT_W       = $clog2(NUM_W + 1);

  localparam logic [TIME_W-1:0] TMAX      = '1;
  localparam logic [TIME_W:0]   TICK_STEP = (TIME_W + 1)'(1) << TIME_FRAC_BITS;

  localparam logic [REG_W-1:0]        SPEED_RESET = 32'd655360;
  localparam logic [REG_W-1:0]        ACCEL_RESET = 32'd16777;
  localparam logic signed [REG_W-1:0] LOWER_RESET = -32'sd1000000;
  localparam logic signed [REG_W-1:0] UPPER_RESET = 32'sd1000000;

  typedef enum logic [1:0] {
    CFG_SPEED = 2'd0,
    CFG_ACCEL = 2'd1,
    CFG_LOWER = 2'd2,
    CFG_UPPER = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_MOVE_REL = 3'd1,
    ACT_MOVE_ABS = 3'd2,
    ACT_SET_POS  = 3'd3,
    ACT_STOP     = 3'd4,
    ACT_ABORT    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_ACCEL = 3'd1,
    ERR_SPEED = 3'd2,
    ERR_ABOVE = 3'd3,
    ERR_BELOW = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [ACC_W-1:0] a;
    logic [B_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] res;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POS,
    ST_POS_OFF,
    ST_ACT,
    ST_PLAN_DIV,
    ST_PLAN_T,
    ST_PLAN_DR,
    ST_PLAN_SQ,
    ST_PLAN_SQD,
    ST_PLAN_CT,
    ST_STOP_A,
    ST_STOP_AD,
    ST_STOP_C,
    ST_STOP_CD,
    ST_STOP_TGT,
    ST_HAD1,
    ST_HAD2,
    ST_HAD3,
    ST_SD1,
    ST_SD2,
    ST_WAIT,
    ST_OUT
  } state_t;

endpackage

@@ sv/trapezoidal_move_profile_core.sv @@
// ----------------------------------------------------------------------------
// trapezoidal_move_profile_core
// One simulated axis with an accelerate, cruise and decelerate profile in
// fixed point. A sequencer drives one shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
// One command beat at a time. Its run time ranges from a tick while idle,
// which uses no arithmetic, to a move while decelerating, with divide,
// square root and ramp distance, set by the bit-serial multiply, divide
// and square root steps of the unit. The next command beat is taken in the
// cycle after a result is registered. Synchronous reset restores register
// defaults and an idle axis at zero.
// ----------------------------------------------------------------------------
module trapezoidal_move_profile_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [2:0]  action,
  input  logic signed [31:0] value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic signed [31:0] position,
  output logic [1:0]  phase,
  output logic        moving,
  output logic [2:0]  error
);

  localparam int PW = tmp_pkg::POS_W;
  localparam int EW = tmp_pkg::EXT_W;
  localparam int TW = tmp_pkg::TIME_W;
  localparam int XW = tmp_pkg::X_W;
  localparam int AW = tmp_pkg::ACC_W;

  tmp_pkg::state_t state, state_next, ret, wret;
  tmp_pkg::alu_req_t alu_req;
  tmp_pkg::alu_rsp_t alu_rsp;

  logic [tmp_pkg::REG_W-1:0] speed, accel;
  logic signed [tmp_pkg::REG_W-1:0] lo_lim, hi_lim;

  logic [PW-1:0] base, target, cur, tgt_r;
  logic          neg, negn, pass;
  logic [TW-1:0] et, rt, ct, rd, cd, fres, tnew, drn;
  logic [PW:0]   mdist, cdn;
  logic [XW-1:0] xarg;
  tmp_pkg::phase_t ph, ph_now;
  tmp_pkg::err_t   err, err_move, err_set;
  logic [2:0]      act_r;
  logic [PW-1:0]   value_r;

  logic [TW:0]     s1, et_inc, dr2;
  logic [TW+1:0]   s2, full, xsel;
  logic [XW-1:0]   off_c;
  logic signed [EW-1:0] pdiff, pneg, sval, scur, dmove, dneg, tgt, lox, hix;
  logic [PW:0]     sp, dabs, cd_c;
  logic [TW-1:0]   et_tick, q_sat, had_sat, sd_sat;
  logic            dr_big, out_free;
  logic [PW-1:0]   cur_new, tgt_stop;

  function automatic logic [PW:0] clamp_off(input logic [XW-1:0] o, input logic [PW:0] s);
    clamp_off = (o > XW'(s)) ? s : o[PW:0];
  endfunction

  function automatic logic [PW-1:0] apply_off(input logic [PW-1:0] b, input logic n,
                                              input logic [PW:0] o);
    logic [PW+1:0] bx, ox, r;
    bx = {{2{b[PW-1]}}, b};
    ox = {1'b0, o};
    r  = n ? bx - ox : bx + ox;
    return r[PW-1:0];
  endfunction

  tmp_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign s1 = {1'b0, rt} + {1'b0, ct};
  assign s2 = {1'b0, rt, 1'b0} + {2'b0, ct};

  always_comb begin
    if (et < rt) begin
      ph_now = tmp_pkg::PH_ACCEL;
      xsel   = {2'b0, et};
    end else if ({1'b0, et} < s1) begin
      ph_now = tmp_pkg::PH_CRUISE;
      xsel   = {2'b0, et - rt};
    end else if ({2'b0, et} < s2) begin
      ph_now = tmp_pkg::PH_DECEL;
      xsel   = s2 - {2'b0, et};
    end else begin
      ph_now = tmp_pkg::PH_IDLE;
      xsel   = '0;
    end
  end

  assign pdiff = {{2{target[PW-1]}}, target} - {{2{base[PW-1]}}, base};
  assign pneg  = -pdiff;
  assign sp    = pdiff[EW-1] ? pneg[PW:0] : pdiff[PW:0];
  assign full  = {1'b0, rd, 1'b0} + {2'b0, cd};

  always_comb begin
    case (ph)
      tmp_pkg::PH_ACCEL:  off_c = {2'b0, fres};
      tmp_pkg::PH_CRUISE: off_c = {1'b0, {1'b0, rd} + {1'b0, fres}};
      tmp_pkg::PH_DECEL:  off_c = ({2'b0, fres} > full) ? '0 : full - {2'b0, fres};
      default:            off_c = '0;
    endcase
  end

  assign cur_new  = apply_off(base, neg, clamp_off(off_c, sp));
  assign tgt_stop = apply_off(base, neg, clamp_off(full, sp));

  assign sval  = {{2{value_r[PW-1]}}, value_r};
  assign scur  = {{2{cur[PW-1]}}, cur};
  assign lox   = {{2{lo_lim[tmp_pkg::REG_W-1]}}, lo_lim};
  assign hix   = {{2{hi_lim[tmp_pkg::REG_W-1]}}, hi_lim};
  assign dmove = (act_r == tmp_pkg::ACT_MOVE_ABS) ? sval - scur : sval;
  assign tgt   = (act_r == tmp_pkg::ACT_MOVE_ABS) ? sval : scur + sval;
  assign dneg  = -dmove;
  assign dabs  = dmove[EW-1] ? dneg[PW:0] : dmove[PW:0];

  always_comb begin
    if (accel == '0)     err_move = tmp_pkg::ERR_ACCEL;
    else if (speed == '0) err_move = tmp_pkg::ERR_SPEED;
    else if (tgt > hix)  err_move = tmp_pkg::ERR_ABOVE;
    else if (tgt < lox)  err_move = tmp_pkg::ERR_BELOW;
    else                 err_move = tmp_pkg::ERR_NONE;
  end

  always_comb begin
    if (sval < lox)      err_set = tmp_pkg::ERR_BELOW;
    else if (sval > hix) err_set = tmp_pkg::ERR_ABOVE;
    else                 err_set = tmp_pkg::ERR_NONE;
  end

  assign et_inc  = {1'b0, et} + tmp_pkg::TICK_STEP;
  assign et_tick = et_inc[TW] ? tmp_pkg::TMAX : et_inc[TW-1:0];
  assign q_sat   = (|alu_rsp.res[AW-1:TW]) ? tmp_pkg::TMAX : alu_rsp.res[TW-1:0];
  assign had_sat = (|alu_rsp.res[AW-1:tmp_pkg::HAD_SHIFT+TW]) ? tmp_pkg::TMAX
                 : alu_rsp.res[tmp_pkg::HAD_SHIFT+TW-1:tmp_pkg::HAD_SHIFT];
  assign sd_sat  = (|alu_rsp.res[AW-1:tmp_pkg::SD_SHIFT+TW]) ? tmp_pkg::TMAX
                 : alu_rsp.res[tmp_pkg::SD_SHIFT+TW-1:tmp_pkg::SD_SHIFT];
  assign dr2     = {fres, 1'b0};
  assign dr_big  = dr2 >= (TW + 1)'(mdist);
  assign cd_c    = mdist - dr2[PW:0];
  assign out_free = !(rsp_valid && rsp_stall);

  always_comb begin
    state_next = state;
    case (state)
      tmp_pkg::ST_IDLE: begin
        if (cmd_valid) state_next = tmp_pkg::ST_POS;
      end
      tmp_pkg::ST_POS: begin
        if (ph_now == tmp_pkg::PH_IDLE) state_next = pass ? tmp_pkg::ST_OUT : tmp_pkg::ST_ACT;
        else if (ph_now == tmp_pkg::PH_CRUISE) state_next = tmp_pkg::ST_SD1;
        else state_next = tmp_pkg::ST_HAD1;
      end
      tmp_pkg::ST_POS_OFF: state_next = pass ? tmp_pkg::ST_OUT : tmp_pkg::ST_ACT;
      tmp_pkg::ST_ACT: begin
        case (act_r)
          tmp_pkg::ACT_MOVE_REL, tmp_pkg::ACT_MOVE_ABS: begin
            if (dmove != '0 && err_move == tmp_pkg::ERR_NONE) state_next = tmp_pkg::ST_PLAN_DIV;
            else state_next = tmp_pkg::ST_POS;
          end
          tmp_pkg::ACT_STOP: begin
            if (ph == tmp_pkg::PH_ACCEL) state_next = tmp_pkg::ST_STOP_A;
            else if (ph == tmp_pkg::PH_CRUISE) state_next = tmp_pkg::ST_STOP_C;
            else state_next = tmp_pkg::ST_POS;
          end
          default: state_next = tmp_pkg::ST_POS;
        endcase
      end
      tmp_pkg::ST_PLAN_DIV: state_next = tmp_pkg::ST_WAIT;
      tmp_pkg::ST_PLAN_T:   state_next = tmp_pkg::ST_HAD1;
      tmp_pkg::ST_PLAN_DR:  state_next = tmp_pkg::ST_WAIT;
      tmp_pkg::ST_PLAN_SQ:  state_next = tmp_pkg::ST_WAIT;
      tmp_pkg::ST_PLAN_SQD: state_next = tmp_pkg::ST_POS;
      tmp_pkg::ST_PLAN_CT:  state_next = tmp_pkg::ST_POS;
      tmp_pkg::ST_STOP_A:   state_next = tmp_pkg::ST_HAD1;
      tmp_pkg::ST_STOP_AD:  state_next = tmp_pkg::ST_STOP_TGT;
      tmp_pkg::ST_STOP_C:   state_next = tmp_pkg::ST_SD1;
      tmp_pkg::ST_STOP_CD:  state_next = tmp_pkg::ST_STOP_TGT;
      tmp_pkg::ST_STOP_TGT: state_next = tmp_pkg::ST_POS;
      tmp_pkg::ST_HAD1:     state_next = tmp_pkg::ST_WAIT;
      tmp_pkg::ST_HAD2:     state_next = tmp_pkg::ST_WAIT;
      tmp_pkg::ST_HAD3:     state_next = ret;
      tmp_pkg::ST_SD1:      state_next = tmp_pkg::ST_WAIT;
      tmp_pkg::ST_SD2:      state_next = ret;
      tmp_pkg::ST_WAIT: begin
        if (alu_rsp.done) state_next = wret;
      end
      tmp_pkg::ST_OUT: begin
        if (out_free) state_next = tmp_pkg::ST_IDLE;
      end
      default: state_next = tmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall     = (state != tmp_pkg::ST_IDLE);
    alu_req.start = 1'b0;
    alu_req.op    = tmp_pkg::ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    case (state)
      tmp_pkg::ST_PLAN_DIV: begin
        alu_req.start = 1'b1;
        alu_req.op    = tmp_pkg::ALU_DIV;
        alu_req.a     = AW'({speed, {tmp_pkg::T_SHIFT{1'b0}}});
        alu_req.b     = tmp_pkg::B_W'(accel);
      end
      tmp_pkg::ST_PLAN_DR: begin
        alu_req.start = 1'b1;
        alu_req.op    = tmp_pkg::ALU_DIV;
        if (dr_big) begin
          alu_req.a = AW'({mdist, {tmp_pkg::SQ_SHIFT{1'b0}}});
          alu_req.b = tmp_pkg::B_W'(accel);
        end else begin
          alu_req.a = AW'({cd_c, {tmp_pkg::C_SHIFT{1'b0}}});
          alu_req.b = tmp_pkg::B_W'(speed);
        end
      end
      tmp_pkg::ST_PLAN_SQ: begin
        alu_req.start = 1'b1;
        alu_req.op    = tmp_pkg::ALU_SQRT;
        alu_req.a     = alu_rsp.res;
      end
      tmp_pkg::ST_HAD1: begin
        alu_req.start = 1'b1;
        alu_req.a     = AW'(xarg);
        alu_req.b     = xarg;
      end
      tmp_pkg::ST_HAD2: begin
        alu_req.start = 1'b1;
        alu_req.a     = alu_rsp.res;
        alu_req.b     = tmp_pkg::B_W'(accel);
      end
      tmp_pkg::ST_SD1: begin
        alu_req.start = 1'b1;
        alu_req.a     = AW'(xarg);
        alu_req.b     = tmp_pkg::B_W'(speed);
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmp_pkg::ST_IDLE;
      ret   <= tmp_pkg::ST_IDLE;
      wret  <= tmp_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
      speed  <= tmp_pkg::SPEED_RESET;
      accel  <= tmp_pkg::ACCEL_RESET;
      lo_lim <= tmp_pkg::LOWER_RESET;
      hi_lim <= tmp_pkg::UPPER_RESET;
      base   <= '0;
      target <= '0;
      neg    <= 1'b0;
      et <= '0;
      rt <= '0;
      ct <= '0;
      rd <= '0;
      cd <= '0;
    end else begin
      state <= state_next;
      rsp_valid <= (state == tmp_pkg::ST_OUT) || (rsp_valid && rsp_stall);
      if (cfg_write) begin
        case (cfg_index)
          tmp_pkg::CFG_SPEED: speed  <= cfg_data;
          tmp_pkg::CFG_ACCEL: accel  <= cfg_data;
          tmp_pkg::CFG_LOWER: lo_lim <= cfg_data;
          tmp_pkg::CFG_UPPER: hi_lim <= cfg_data;
          default:            speed  <= speed;
        endcase
      end
      case (state)
        tmp_pkg::ST_POS: begin
          ret <= tmp_pkg::ST_POS_OFF;
          if (ph_now == tmp_pkg::PH_IDLE) base <= target;
        end
        tmp_pkg::ST_ACT: begin
          case (act_r)
            tmp_pkg::ACT_TICK: et <= et_tick;
            tmp_pkg::ACT_SET_POS: begin
              if (err_set == tmp_pkg::ERR_NONE) begin
                base   <= value_r;
                target <= value_r;
                et <= '0;
                rt <= '0;
                ct <= '0;
                rd <= '0;
                cd <= '0;
              end
            end
            tmp_pkg::ACT_ABORT: begin
              base   <= cur;
              target <= cur;
              et <= '0;
              rt <= '0;
              ct <= '0;
              rd <= '0;
              cd <= '0;
            end
            default: et <= et;
          endcase
        end
        tmp_pkg::ST_PLAN_DIV: wret <= tmp_pkg::ST_PLAN_T;
        tmp_pkg::ST_PLAN_T:   ret  <= tmp_pkg::ST_PLAN_DR;
        tmp_pkg::ST_PLAN_DR:  wret <= dr_big ? tmp_pkg::ST_PLAN_SQ : tmp_pkg::ST_PLAN_CT;
        tmp_pkg::ST_PLAN_SQ:  wret <= tmp_pkg::ST_PLAN_SQD;
        tmp_pkg::ST_PLAN_SQD: begin
          rt <= alu_rsp.res[TW-1:0];
          rd <= TW'(mdist >> 1);
          cd <= '0;
          ct <= '0;
          neg    <= negn;
          base   <= cur;
          target <= tgt_r;
          et     <= '0;
        end
        tmp_pkg::ST_PLAN_CT: begin
          rt <= tnew;
          rd <= drn;
          cd <= TW'(cdn);
          ct <= q_sat;
          neg    <= negn;
          base   <= cur;
          target <= tgt_r;
          et     <= '0;
        end
        tmp_pkg::ST_STOP_A: begin
          rt  <= et;
          ct  <= '0;
          cd  <= '0;
          ret <= tmp_pkg::ST_STOP_AD;
        end
        tmp_pkg::ST_STOP_AD: rd <= fres;
        tmp_pkg::ST_STOP_C: begin
          ct  <= et - rt;
          ret <= tmp_pkg::ST_STOP_CD;
        end
        tmp_pkg::ST_STOP_CD:  cd <= fres;
        tmp_pkg::ST_STOP_TGT: target <= tgt_stop;
        tmp_pkg::ST_HAD1:     wret <= tmp_pkg::ST_HAD2;
        tmp_pkg::ST_HAD2:     wret <= tmp_pkg::ST_HAD3;
        tmp_pkg::ST_SD1:      wret <= tmp_pkg::ST_SD2;
        default: begin
          wret <= wret;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tmp_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          act_r   <= action;
          value_r <= value;
          pass    <= 1'b0;
          err     <= tmp_pkg::ERR_NONE;
        end
      end
      tmp_pkg::ST_POS: begin
        ph   <= ph_now;
        xarg <= xsel;
        if (ph_now == tmp_pkg::PH_IDLE) cur <= target;
      end
      tmp_pkg::ST_POS_OFF: begin
        cur <= cur_new;
      end
      tmp_pkg::ST_ACT: begin
        pass <= 1'b1;
        case (act_r)
          tmp_pkg::ACT_MOVE_REL, tmp_pkg::ACT_MOVE_ABS: begin
            if (dmove != '0) begin
              err   <= err_move;
              mdist <= dabs;
              tgt_r <= tgt[PW-1:0];
              negn  <= dmove[EW-1];
            end
          end
          tmp_pkg::ACT_SET_POS: err <= err_set;
          default: err <= err;
        endcase
      end
      tmp_pkg::ST_PLAN_T: begin
        tnew <= q_sat;
        xarg <= XW'(q_sat);
      end
      tmp_pkg::ST_PLAN_DR: begin
        drn <= fres;
        cdn <= cd_c;
      end
      tmp_pkg::ST_STOP_A: xarg <= XW'(et);
      tmp_pkg::ST_STOP_C: xarg <= XW'(et - rt);
      tmp_pkg::ST_HAD3:   fres <= had_sat;
      tmp_pkg::ST_SD2:    fres <= sd_sat;
      tmp_pkg::ST_OUT: begin
        if (out_free) begin
          position <= cur;
          phase    <= ph;
          moving   <= (ph != tmp_pkg::PH_IDLE);
          error    <= err;
        end
      end
      default: begin
        pass <= pass;
      end
    endcase
  end

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == tmp_pkg::ST_OUT)
    else $error("result beat raised outside the output state");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> state == tmp_pkg::ST_WAIT)
    else $error("arithmetic unit finished while the sequencer was not waiting");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("command beat accepted without starting work");

  a_moving_phase: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (moving == (phase != tmp_pkg::PH_IDLE)))
    else $error("moving flag disagrees with phase");

endmodule

@@ sv/tmp_alu.sv @@
// ----------------------------------------------------------------------------
// tmp_alu
// Iterative arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one step per cycle on a shared accumulator.
// ----------------------------------------------------------------------------
module tmp_alu (
  input  logic              clk,
  input  logic              rst,
  input  tmp_pkg::alu_req_t req,
  output tmp_pkg::alu_rsp_t rsp
);

  logic                      busy;
  logic                      done;
  tmp_pkg::alu_op_t          op;
  logic [tmp_pkg::ACC_W-1:0] acc;
  logic [tmp_pkg::ACC_W-1:0] sh;
  logic [tmp_pkg::B_W-1:0]   opb;
  logic [tmp_pkg::REM_W-1:0] rem;
  logic [tmp_pkg::CNT_W-1:0] cnt;

  logic [tmp_pkg::ACC_W-1:0] mul_sum;
  logic [tmp_pkg::REM_W-1:0] sub_x;
  logic [tmp_pkg::REM_W-1:0] sub_y;
  logic [tmp_pkg::REM_W-1:0] sub_d;
  logic                      sub_ge;
  logic                      last;

  assign mul_sum = acc + (opb[0] ? sh : '0);

  always_comb begin
    if (op == tmp_pkg::ALU_SQRT) begin
      sub_x = {rem[tmp_pkg::REM_W-3:0], sh[tmp_pkg::NUM_W-1:tmp_pkg::NUM_W-2]};
      sub_y = {acc[tmp_pkg::REM_W-3:0], 2'b01};
    end else begin
      sub_x = {rem[tmp_pkg::REM_W-2:0], sh[tmp_pkg::NUM_W-1]};
      sub_y = tmp_pkg::REM_W'(opb[tmp_pkg::REG_W-1:0]);
    end
  end

  assign sub_ge = sub_x >= sub_y;
  assign sub_d  = sub_x - sub_y;
  assign last   = (op == tmp_pkg::ALU_MUL) ? (opb == '0) : (cnt == tmp_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      acc <= '0;
      sh  <= req.a;
      opb <= req.b;
      rem <= '0;
      cnt <= (req.op == tmp_pkg::ALU_SQRT) ? tmp_pkg::CNT_W'(tmp_pkg::SQRT_STEPS)
                                           : tmp_pkg::CNT_W'(tmp_pkg::DIV_STEPS);
    end else if (busy) begin
      case (op)
        tmp_pkg::ALU_MUL: begin
          if (opb != '0) begin
            acc <= mul_sum;
            sh  <= sh << 1;
            opb <= opb >> 1;
          end
        end
        tmp_pkg::ALU_DIV: begin
          rem <= sub_ge ? sub_d : sub_x;
          acc <= {acc[tmp_pkg::ACC_W-2:0], sub_ge};
          sh  <= sh << 1;
          cnt <= cnt - tmp_pkg::CNT_W'(1);
        end
        tmp_pkg::ALU_SQRT: begin
          rem <= sub_ge ? sub_d : sub_x;
          acc <= {acc[tmp_pkg::ACC_W-2:0], sub_ge};
          sh  <= sh << 2;
          cnt <= cnt - tmp_pkg::CNT_W'(1);
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.res  = acc;

endmodule

@@ bench/trapezoidal_move_profile_checker.sv @@
// ----------------------------------------------------------------------------
// trapezoidal_move_profile_checker
// Watches the configuration port and both beat channels of the move profile
// core. It keeps its own fixed-point copy of the axis, works out the result
// of every accepted command beat and compares each result beat with it.
// ----------------------------------------------------------------------------
module trapezoidal_move_profile_checker
  import tmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  logic signed [31:0] position,
  input  logic [1:0]         phase,
  input  logic               moving,
  input  logic [2:0]         error,
  output int                 awaiting,
  output int                 fails
);

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic signed [31:0] pos;
    phase_t             ph;
    logic               mv;
    err_t               er;
  } axis_result_t;

  localparam u64_t TIME_LIM = 64'(TMAX);

  axis_result_t expected_q[$];

  u64_t    speed, accel;
  longint  lower_lim, upper_lim;
  longint  base_pos, target_pos;
  bit      heading_neg;
  u64_t    elapsed, ramp_t, cruise_t, ramp_d, cruise_d;

  function automatic u64_t clip_time(input logic [127:0] x);
    return (x > 128'(TIME_LIM)) ? TIME_LIM : x[63:0];
  endfunction

  function automatic u64_t ramp_offset(input u64_t t);
    logic [127:0] p;
    p = 128'(t) * 128'(t) * 128'(accel);
    return clip_time(p >> HAD_SHIFT);
  endfunction

  function automatic u64_t cruise_offset(input u64_t t);
    logic [127:0] p;
    p = 128'(t) * 128'(speed);
    return clip_time(p >> SD_SHIFT);
  endfunction

  function automatic longint wrap_pos(input longint p);
    logic [63:0] u;
    u = p;
    return longint'($signed(u[31:0]));
  endfunction

  function automatic u64_t travel_span();
    longint d;
    d = target_pos - base_pos;
    return (d < 0) ? u64_t'(-d) : u64_t'(d);
  endfunction

  function automatic longint axis_now(output phase_t ph);
    u64_t off, sp, h, full;
    if (elapsed < ramp_t) begin
      ph = PH_ACCEL;
      off = ramp_offset(elapsed);
    end else if (elapsed < ramp_t + cruise_t) begin
      ph = PH_CRUISE;
      off = ramp_d + cruise_offset(elapsed - ramp_t);
    end else if (elapsed < 2 * ramp_t + cruise_t) begin
      ph = PH_DECEL;
      h = ramp_offset(2 * ramp_t + cruise_t - elapsed);
      full = 2 * ramp_d + cruise_d;
      off = (h > full) ? 0 : full - h;
    end else begin
      ph = PH_IDLE;
      base_pos = target_pos;
      return target_pos;
    end
    sp = travel_span();
    if (off > sp) off = sp;
    return heading_neg ? base_pos - longint'(off) : base_pos + longint'(off);
  endfunction

  function automatic void park_at(input longint p);
    base_pos = p;
    target_pos = p;
    elapsed = 0;
    ramp_t = 0;
    cruise_t = 0;
    ramp_d = 0;
    cruise_d = 0;
  endfunction

  function automatic err_t plan_travel(input longint cur, input longint d);
    longint       tgt;
    u64_t         mdist, t, dr, cd, c, probe;
    logic [127:0] lim;
    tgt = cur + d;
    if (d == 0) return ERR_NONE;
    if (accel == 0) return ERR_ACCEL;
    if (speed == 0) return ERR_SPEED;
    if (tgt > upper_lim) return ERR_ABOVE;
    if (tgt < lower_lim) return ERR_BELOW;
    heading_neg = d < 0;
    mdist = (d < 0) ? u64_t'(-d) : u64_t'(d);
    t = (speed << T_SHIFT) / accel;
    if (t > TIME_LIM) t = TIME_LIM;
    dr = ramp_offset(t);
    if (2 * dr >= mdist) begin
      lim = 128'(mdist) << SQ_SHIFT;
      t = 0;
      for (int k = 39; k >= 0; k--) begin
        probe = t | (u64_t'(1) << k);
        if (128'(probe) * 128'(probe) * 128'(accel) <= lim) t = probe;
      end
      ramp_d = mdist / 2;
      cruise_d = 0;
      cruise_t = 0;
    end else begin
      cd = mdist - 2 * dr;
      lim = 128'(cd) << C_SHIFT;
      c = 0;
      for (int k = 39; k >= 0; k--) begin
        probe = c | (u64_t'(1) << k);
        if (128'(probe) * 128'(speed) <= lim) c = probe;
      end
      ramp_d = dr;
      cruise_d = cd;
      cruise_t = c;
    end
    ramp_t = t;
    base_pos = wrap_pos(cur);
    target_pos = wrap_pos(tgt);
    elapsed = 0;
    return ERR_NONE;
  endfunction

  function automatic void begin_stop();
    phase_t ph;
    longint cur;
    u64_t   off, sp;
    cur = axis_now(ph);
    sp = travel_span();
    if (ph == PH_ACCEL) begin
      ramp_t = elapsed;
      ramp_d = ramp_offset(ramp_t);
      cruise_t = 0;
      cruise_d = 0;
    end else if (ph == PH_CRUISE) begin
      cruise_t = elapsed - ramp_t;
      cruise_d = cruise_offset(cruise_t);
    end else begin
      return;
    end
    off = 2 * ramp_d + cruise_d;
    if (off > sp) off = sp;
    target_pos = heading_neg ? base_pos - longint'(off) : base_pos + longint'(off);
  endfunction

  function automatic axis_result_t apply_command(input logic [2:0] act,
                                                 input logic signed [31:0] v);
    axis_result_t r;
    phase_t       ph;
    err_t         er;
    longint       val, cur;
    er = ERR_NONE;
    val = longint'(v);
    cur = axis_now(ph);
    case (act)
      ACT_TICK: begin
        elapsed = elapsed + u64_t'(TICK_STEP);
        if (elapsed > TIME_LIM) elapsed = TIME_LIM;
      end
      ACT_MOVE_REL: er = plan_travel(cur, val);
      ACT_MOVE_ABS: er = plan_travel(cur, val - cur);
      ACT_SET_POS: begin
        if (val < lower_lim) er = ERR_BELOW;
        else if (val > upper_lim) er = ERR_ABOVE;
        else park_at(wrap_pos(val));
      end
      ACT_STOP: begin_stop();
      ACT_ABORT: park_at(cur);
      default: ;
    endcase
    cur = axis_now(ph);
    r.pos = cur[31:0];
    r.ph = ph;
    r.mv = (ph != PH_IDLE);
    r.er = er;
    return r;
  endfunction

  initial begin
    fails = 0;
    awaiting = 0;
  end

  always @(posedge clk) begin
    axis_result_t want;
    if (rst) begin
      speed = 64'(SPEED_RESET);
      accel = 64'(ACCEL_RESET);
      lower_lim = longint'(LOWER_RESET);
      upper_lim = longint'(UPPER_RESET);
      heading_neg = 0;
      park_at(0);
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SPEED: speed = 64'(cfg_data);
          CFG_ACCEL: accel = 64'(cfg_data);
          CFG_LOWER: lower_lim = longint'($signed(cfg_data));
          CFG_UPPER: upper_lim = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (cmd_valid && !cmd_stall) expected_q.push_back(apply_command(action, value));
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, position %0d", $time, position);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (position !== want.pos) begin
            $display("%0t: position expected %0d actual %0d", $time, want.pos, position);
            fails++;
          end
          if (phase !== want.ph) begin
            $display("%0t: phase expected %0d actual %0d", $time, want.ph, phase);
            fails++;
          end
          if (moving !== want.mv) begin
            $display("%0t: moving expected %0d actual %0d", $time, want.mv, moving);
            fails++;
          end
          if (error !== want.er) begin
            $display("%0t: error expected %0d actual %0d", $time, want.er, error);
            fails++;
          end
        end
      end
    end
    awaiting = expected_q.size();
  end

endmodule

@@ bench/trapezoidal_move_profile_core_test.sv @@
// ----------------------------------------------------------------------------
// trapezoidal_move_profile_core_test
// Drives the move profile core with a directed set of commands and register
// settings, then random move, set-position, tick, stop and abort sequences under several
// profiles, with random gaps and stalls. The checker judges every beat.
// ----------------------------------------------------------------------------
module trapezoidal_move_profile_core_test;
  import tmp_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_write = 0;
  logic [1:0]         cfg_index = CFG_SPEED;
  logic [31:0]        cfg_data = 0;
  logic               cmd_valid = 0;
  logic               cmd_stall;
  logic [2:0]         action = ACT_TICK;
  logic signed [31:0] value = 0;
  logic               rsp_valid;
  logic               rsp_stall = 0;
  logic signed [31:0] position;
  logic [1:0]         phase;
  logic               moving;
  logic [2:0]         error;
  int                 awaiting, fails;
  bit                 stimulus_done = 0;

  trapezoidal_move_profile_core uut (.*);

  trapezoidal_move_profile_checker chk (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic issue(input action_t a, input logic signed [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) cmd_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid = 1;
    action = a;
    value = v;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic drain();
    @(negedge clk) cmd_valid = 0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    drain();
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk) cfg_write = 0;
  endtask

  task automatic run_ticks(input int n);
    repeat (n) issue(ACT_TICK, $urandom);
  endtask

  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) rsp_stall = 0;
    else if (r < 97) rsp_stall = 1;
    else begin
      rsp_stall = 1;
      repeat ($urandom_range(5, 40)) @(negedge clk);
    end
  end

  initial begin
    int               count, r;
    logic signed [31:0] v;
    repeat (4) @(negedge clk);
    rst = 0;

    issue(ACT_MOVE_REL, 0);
    issue(ACT_SET_POS, 32'sh7fffffff);
    issue(ACT_SET_POS, 32'sh80000000);
    issue(ACT_MOVE_ABS, 32'sh7fffffff);
    issue(ACT_MOVE_REL, 32'sh80000000);
    issue(ACT_MOVE_REL, 20);
    run_ticks(2);
    write_reg(CFG_SPEED, 32'h0008_0000);
    write_reg(CFG_ACCEL, 32'h0100_0000);
    issue(ACT_MOVE_REL, -300);
    run_ticks(4);
    issue(ACT_STOP, 0);
    run_ticks(30);
    issue(ACT_MOVE_ABS, 150);
    run_ticks(15);
    issue(ACT_STOP, 0);
    issue(ACT_MOVE_REL, 40);
    run_ticks(3);
    issue(ACT_ABORT, 0);
    issue(ACT_SET_POS, 5);
    issue(action_t'(3'd6), 32'sh5a5a5a5a);
    issue(action_t'(3'd7), 32'sha5a5a5a5);
    issue(ACT_STOP, 0);
    write_reg(CFG_ACCEL, 0);
    issue(ACT_MOVE_REL, 10);
    write_reg(CFG_SPEED, 0);
    issue(ACT_MOVE_REL, 10);
    write_reg(CFG_ACCEL, 32'h0100_0000);
    issue(ACT_MOVE_REL, 10);
    write_reg(CFG_SPEED, 32'hffff_ffff);
    write_reg(CFG_ACCEL, 1);
    issue(ACT_MOVE_REL, 1000);
    run_ticks(3);
    write_reg(CFG_SPEED, 1);
    write_reg(CFG_ACCEL, 32'hffff_ffff);
    issue(ACT_MOVE_REL, -7);
    run_ticks(3);
    write_reg(CFG_LOWER, 32'sh7fffffff);
    write_reg(CFG_UPPER, 32'sh80000000);
    issue(ACT_MOVE_REL, 1);
    issue(ACT_SET_POS, 0);
    write_reg(CFG_LOWER, 32'sh80000000);
    write_reg(CFG_UPPER, 32'sh7fffffff);
    issue(ACT_SET_POS, 32'sh7fffffff);
    issue(ACT_MOVE_REL, 32'sh80000000);
    run_ticks(2);
    issue(ACT_ABORT, 0);

    count = 0;
    while (count < 500) begin
      if (count % 120 == 0) begin
        write_reg(CFG_SPEED, $urandom_range(32'h0001_0000, 32'h0010_0000));
        write_reg(CFG_ACCEL, $urandom_range(32'h0040_0000, 32'h0400_0000));
        write_reg(CFG_LOWER, -$urandom_range(0, 3000));
        write_reg(CFG_UPPER, $urandom_range(0, 3000));
        issue(ACT_SET_POS, 0);
      end
      r = $urandom_range(0, 99);
      if (r < 20) begin
        v = $urandom_range(1, 500);
        issue(ACT_MOVE_REL, ($urandom_range(0, 1) != 0) ? -v : v);
      end else if (r < 30) begin
        issue(ACT_MOVE_ABS, $signed($urandom_range(0, 6000)) - 3000);
      end else if (r < 34) begin
        issue(ACT_SET_POS, $signed($urandom_range(0, 7000)) - 3500);
      end else if (r < 40) begin
        issue(ACT_STOP, $urandom);
      end else if (r < 43) begin
        issue(ACT_ABORT, $urandom);
      end else if (r < 48) begin
        issue(action_t'(3'($urandom_range(0, 7))), $urandom);
      end else begin
        issue(ACT_TICK, $urandom);
      end
      count++;
    end

    drain();
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    repeat (600) @(posedge clk);
    if (fails == 0 && awaiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
sv/tmp_pkg.sv
sv/tmp_alu.sv
sv/trapezoidal_move_profile_core.sv
bench/trapezoidal_move_profile_checker.sv
bench/trapezoidal_move_profile_core_test.sv
